// ===== hdl/vwhd_pkg.sv =====
package vwhd_pkg;

  // Table sizes and derived widths.
  localparam int MAX_VERTICES = 4096;
  localparam int TABLE_SLOTS  = 8192;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);
  localparam int SLOT_AW      = $clog2(TABLE_SLOTS);
  localparam int CNT_W        = VTX_AW + 1;
  localparam int STEP_W       = SLOT_AW + 1;
  localparam int COORD_W      = 32;
  localparam int VTX_W        = 3 * COORD_W;
  localparam int IDX_W        = 12;
  localparam int ST_W         = 2;
  localparam int BYTES        = VTX_W / 8;
  localparam int BYTE_CW      = $clog2(BYTES);

  // FNV-1a constants.
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_MATCH = 2'd0;
  localparam logic [ST_W-1:0] ST_NEW   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            clear;
    logic            load;
    logic            hash_step;
    logic            slot_rd;
    logic            append;
    logic            vert_rd;
    logic            advance;
    logic            res_valid;
    logic [ST_W-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic slot_empty;
    logic store_full;
    logic vert_match;
    logic steps_last;
  } sts_t;

endpackage

// ===== hdl/vwhd_ram.sv =====
module vwhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/vwhd_datapath.sv =====
module vwhd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vwhd_pkg::cmd_t                   cmd,
  output vwhd_pkg::sts_t                   sts,
  input  logic [31:0]                      in_pos_x,
  input  logic [31:0]                      in_pos_y,
  input  logic [31:0]                      in_pos_z,
  output logic                             out_valid,
  output logic [11:0]                      out_vertex_index,
  output logic [1:0]                       out_status
);
  import vwhd_pkg::*;

  logic [VTX_W-1:0]   vtx_r;
  logic [31:0]        hash_r;
  logic [BYTE_CW-1:0] byte_r;
  logic [SLOT_AW-1:0] pos_r;
  logic [STEP_W-1:0]  steps_r;
  logic [CNT_W-1:0]   count_r;
  logic [SLOT_AW-1:0] clr_r;
  logic [CNT_W-1:0]   idx_r;
  logic               idx_ok_r;
  logic               valid_r;
  logic [IDX_W-1:0]   index_r;
  logic [ST_W-1:0]    status_r;

  logic [31:0]        fold_x, fold_y, fold_z;
  logic [7:0]         cur_byte;
  logic [31:0]        hash_nxt;
  logic [CNT_W-1:0]   slot_q;
  logic [VTX_W-1:0]   vert_q;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_addr;
  logic [CNT_W-1:0]   slot_wdata;
  logic               vert_we;
  logic [VTX_AW-1:0]  vert_addr;
  logic [CNT_W-1:0]   idx_cur;

  // Negative zero folds to positive zero.
  assign fold_x = (in_pos_x == NEG_ZERO) ? '0 : in_pos_x;
  assign fold_y = (in_pos_y == NEG_ZERO) ? '0 : in_pos_y;
  assign fold_z = (in_pos_z == NEG_ZERO) ? '0 : in_pos_z;

  // One FNV-1a byte step per cycle, low byte of x first.
  assign cur_byte = vtx_r[byte_r*8 +: 8];
  assign hash_nxt = (hash_r ^ {24'd0, cur_byte}) * FNV_PRIME;

  assign idx_cur = slot_q - CNT_W'(1);

  // Memory port muxing.
  assign slot_we    = cmd.clear | cmd.append;
  assign slot_addr  = cmd.clear ? clr_r : pos_r;
  assign slot_wdata = cmd.clear ? '0 : count_r + CNT_W'(1);
  assign vert_we    = cmd.append;
  assign vert_addr  = cmd.append ? count_r[VTX_AW-1:0] : idx_cur[VTX_AW-1:0];

  vwhd_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_SLOTS)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_q)
  );

  vwhd_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vert (
    .clk   (clk),
    .we    (vert_we),
    .addr  (vert_addr),
    .wdata (vtx_r),
    .rdata (vert_q)
  );

  // Control state: clear sweep, vertex count, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + SLOT_AW'(1);
      end
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end
      valid_r <= cmd.res_valid;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vtx_r   <= {fold_z, fold_y, fold_x};
      hash_r  <= FNV_BASIS;
      byte_r  <= '0;
      steps_r <= '0;
    end
    if (cmd.hash_step) begin
      hash_r <= hash_nxt;
      byte_r <= byte_r + BYTE_CW'(1);
      pos_r  <= hash_nxt[SLOT_AW-1:0];
    end
    if (cmd.vert_rd) begin
      idx_r    <= idx_cur;
      idx_ok_r <= (idx_cur < count_r) && (idx_cur < CNT_W'(MAX_VERTICES));
    end
    if (cmd.advance) begin
      pos_r   <= pos_r + SLOT_AW'(1);
      steps_r <= steps_r + STEP_W'(1);
    end
    if (cmd.res_valid) begin
      status_r <= cmd.res_status;
      unique case (cmd.res_status)
        ST_NEW:   index_r <= count_r[IDX_W-1:0];
        ST_MATCH: index_r <= idx_r[IDX_W-1:0];
        default:  index_r <= '0;
      endcase
    end
  end

  // Status back to the controller.
  assign sts.clr_last   = (clr_r == SLOT_AW'(TABLE_SLOTS - 1));
  assign sts.hash_last  = (byte_r == BYTE_CW'(BYTES - 1));
  assign sts.slot_empty = (slot_q == '0);
  assign sts.store_full = (count_r >= CNT_W'(MAX_VERTICES));
  assign sts.vert_match = idx_ok_r && (vert_q == vtx_r);
  assign sts.steps_last = (steps_r == STEP_W'(TABLE_SLOTS - 1));

  assign out_valid        = valid_r;
  assign out_vertex_index = index_r;
  assign out_status       = status_r;

`ifndef NO_ASSERTIONS
  // The store never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count overflow");

  // An append always bumps the count by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count not bumped on append");

  // A full result carries index zero.
  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_FULL) |-> index_r == '0)
    else $error("full result with nonzero index");
`endif

endmodule

// ===== hdl/vwhd_ctrl.sv =====
module vwhd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  vwhd_pkg::sts_t sts,
  output vwhd_pkg::cmd_t cmd
);
  import vwhd_pkg::*;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_HASH     = 3'd2;
  localparam logic [2:0] S_SLOT_RD  = 3'd3;
  localparam logic [2:0] S_SLOT_CHK = 3'd4;
  localparam logic [2:0] S_VERT_CHK = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) state_nxt = S_SLOT_RD;
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (sts.slot_empty) begin
          cmd.res_valid = 1'b1;
          if (sts.store_full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.append     = 1'b1;
            cmd.res_status = ST_NEW;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.vert_rd = 1'b1;
          state_nxt   = S_VERT_CHK;
        end
      end
      S_VERT_CHK: begin
        if (sts.vert_match) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_MATCH;
          state_nxt      = S_IDLE;
        end else if (sts.steps_last) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_SLOT_RD;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  // An accepted word always enters hashing.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_HASH)
    else $error("accepted word did not start hashing");

  // Append happens only on an empty slot with room in the store.
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (sts.slot_empty && !sts.store_full))
    else $error("append without room");

  // A result always returns the controller to idle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_valid |=> state_r == S_IDLE)
    else $error("result without return to idle");
`endif

endmodule

// ===== hdl/vertex_weld_hash_dedup.sv =====
// Flow: the word is hashed byte by byte, then each probed slot is read and checked, and for an occupied
// slot its stored vertex is compared; the result strobe is registered in the cycle after the decision.
// A new word is accepted only in idle, once the last result is out; the single-port slot table and vertex store
// hold one word in flight. Reset: synchronous rst_n; afterwards every slot table entry is cleared with busy high.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
module vertex_weld_hash_dedup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  output logic        out_valid,
  output logic [11:0] out_vertex_index,
  output logic [1:0]  out_status
);
  import vwhd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vwhd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  vwhd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_valid        (out_valid),
    .out_vertex_index (out_vertex_index),
    .out_status       (out_status)
  );

endmodule
